@@ hw/rtl/dfcr_pkg.sv @@
package dfcr_pkg;

	localparam logic [7:0] DLE = 8'h10;
	localparam logic [7:0] STX = 8'h02;
	localparam logic [7:0] ETX = 8'h03;

	localparam logic [7:0] PING_ID0 = 8'h4A;
	localparam logic [7:0] PING_ID1 = 8'h55;
	localparam logic [7:0] PING_ID2 = 8'h0F;
	localparam int unsigned PING_MIN_LEN = 3;

	localparam int unsigned REC_IDX_W = 5;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_SOF_DLE,
		SEQ_SOF_STX,
		SEQ_DATA,
		SEQ_STUFF,
		SEQ_EOF_DLE,
		SEQ_EOF_ETX
	} seq_state_t;

	typedef struct packed {
		logic launch;
		logic ping;
	} frame_ctl_t;

	function automatic logic [7:0] ping_byte(input logic [REC_IDX_W-1:0] idx);
		logic [7:0] b;
		unique case (idx)
			5'd0: b = 8'h4A;
			5'd1: b = 8'hAA;
			5'd2: b = 8'hF0;
			5'd6: b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ hw/rtl/dfcr_rx_if.sv @@
interface dfcr_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/dfcr_reply_if.sv @@
interface dfcr_reply_if;
	logic       valid;
	logic       ready;
	logic [7:0] reply_byte;
	logic       reply_last;

	modport source (output valid, output reply_byte, output reply_last, input ready);
	modport sink (input valid, input reply_byte, input reply_last, output ready);
endinterface

@@ hw/rtl/dfcr_deframer.sv @@
module dfcr_deframer #(
	parameter int MAX_PAYLOAD = 64,
	parameter int RECORD_LEN = 7,
	parameter int CNT_W = 7
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             accept,
	input  logic [7:0]                       rx_byte,
	output logic [CNT_W-1:0]                 count,
	output logic [RECORD_LEN-1:0][7:0]       store,
	output dfcr_pkg::frame_ctl_t             ctl
);

	localparam int IDX_W = $clog2(RECORD_LEN);

	logic                       inside_q, inside_d;
	logic                       esc_q, esc_d;
	logic [CNT_W-1:0]           count_q, count_d;
	logic [RECORD_LEN-1:0][7:0] store_q;
	logic                       push;
	logic                       room;
	logic                       we;
	logic                       launch;

	assign room = count_q < CNT_W'(MAX_PAYLOAD);
	assign we   = push && room && (count_q < CNT_W'(RECORD_LEN));

	always_comb begin
		inside_d = inside_q;
		esc_d    = esc_q;
		count_d  = count_q;
		push     = 1'b0;
		launch   = 1'b0;
		if (accept) begin
			if (!inside_q) begin
				if (esc_q && rx_byte == dfcr_pkg::STX) begin
					inside_d = 1'b1;
					count_d  = '0;
					esc_d    = 1'b0;
				end else begin
					esc_d = (rx_byte == dfcr_pkg::DLE);
				end
			end else if (esc_q) begin
				esc_d = 1'b0;
				if (rx_byte == dfcr_pkg::DLE) begin
					push = 1'b1;
				end else begin
					inside_d = 1'b0;
					if (rx_byte == dfcr_pkg::ETX) begin
						launch = (count_q != '0);
					end else begin
						count_d = '0;
					end
				end
			end else if (rx_byte == dfcr_pkg::DLE) begin
				if (count_q >= CNT_W'(RECORD_LEN)) begin
					inside_d = 1'b0;
					launch   = (count_q != '0);
				end else begin
					esc_d = 1'b1;
				end
			end else begin
				push = 1'b1;
			end
		end
		if (push && room) begin
			count_d = count_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			esc_q    <= 1'b0;
			count_q  <= '0;
		end else begin
			inside_q <= inside_d;
			esc_q    <= esc_d;
			count_q  <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[count_q[IDX_W-1:0]] <= rx_byte;
		end
	end

	assign count      = count_q;
	assign store      = store_q;
	assign ctl.launch = launch;
	assign ctl.ping   = (count_q >= CNT_W'(dfcr_pkg::PING_MIN_LEN)) &&
	                    (store_q[0] == dfcr_pkg::PING_ID0) &&
	                    (store_q[1] == dfcr_pkg::PING_ID1) &&
	                    (store_q[2] == dfcr_pkg::PING_ID2);

`ifndef SYNTHESIS
	a_launch_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		launch |-> inside_q)
		else $error("reply launched outside a frame");
	a_launch_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		launch |-> (count_q != '0))
		else $error("reply launched for an empty frame");
	a_open_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(inside_q) |-> (count_q == '0))
		else $error("frame opened with a stale payload count");
`endif

endmodule

@@ hw/rtl/dfcr_reply_seq.sv @@
module dfcr_reply_seq #(
	parameter int RECORD_LEN = 7,
	parameter int CNT_W = 7
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dfcr_pkg::frame_ctl_t       ctl,
	input  logic [CNT_W-1:0]           count,
	input  logic [RECORD_LEN-1:0][7:0] store,
	output logic                       idle,
	dfcr_reply_if.source               reply
);

	localparam int IDX_W = $clog2(RECORD_LEN);

	dfcr_pkg::seq_state_t state_q, state_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic                 ping_q, ping_d;
	logic                 ov_q;
	logic [7:0]           ob_q;
	logic                 ol_q;
	logic                 adv;
	logic                 load;
	logic [7:0]           load_byte;
	logic                 load_last;
	logic [7:0]           rec_byte;
	logic                 is_dle;
	logic                 last_idx;

	assign adv      = !ov_q || reply.ready;
	assign is_dle   = (rec_byte == dfcr_pkg::DLE);
	assign last_idx = (idx_q == IDX_W'(RECORD_LEN - 1));

	always_comb begin
		if (ping_q) begin
			rec_byte = dfcr_pkg::ping_byte(dfcr_pkg::REC_IDX_W'(idx_q));
		end else if (CNT_W'(idx_q) < count) begin
			rec_byte = store[idx_q];
		end else begin
			rec_byte = 8'h00;
		end
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		ping_d    = ping_q;
		load      = 1'b0;
		load_byte = dfcr_pkg::DLE;
		load_last = 1'b0;
		unique case (state_q)
			dfcr_pkg::SEQ_IDLE: begin
				if (ctl.launch) begin
					state_d = dfcr_pkg::SEQ_SOF_DLE;
					idx_d   = '0;
					ping_d  = ctl.ping;
				end
			end
			dfcr_pkg::SEQ_SOF_DLE: begin
				if (adv) begin
					load    = 1'b1;
					state_d = dfcr_pkg::SEQ_SOF_STX;
				end
			end
			dfcr_pkg::SEQ_SOF_STX: begin
				if (adv) begin
					load      = 1'b1;
					load_byte = dfcr_pkg::STX;
					state_d   = dfcr_pkg::SEQ_DATA;
				end
			end
			dfcr_pkg::SEQ_DATA: begin
				if (adv) begin
					load      = 1'b1;
					load_byte = rec_byte;
					if (is_dle) begin
						state_d = dfcr_pkg::SEQ_STUFF;
					end else if (last_idx) begin
						state_d = dfcr_pkg::SEQ_EOF_DLE;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			dfcr_pkg::SEQ_STUFF: begin
				if (adv) begin
					load = 1'b1;
					if (last_idx) begin
						state_d = dfcr_pkg::SEQ_EOF_DLE;
					end else begin
						idx_d   = idx_q + 1'b1;
						state_d = dfcr_pkg::SEQ_DATA;
					end
				end
			end
			dfcr_pkg::SEQ_EOF_DLE: begin
				if (adv) begin
					load    = 1'b1;
					state_d = dfcr_pkg::SEQ_EOF_ETX;
				end
			end
			dfcr_pkg::SEQ_EOF_ETX: begin
				if (adv) begin
					load      = 1'b1;
					load_byte = dfcr_pkg::ETX;
					load_last = 1'b1;
					state_d   = dfcr_pkg::SEQ_IDLE;
				end
			end
			default: begin
				state_d = dfcr_pkg::SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dfcr_pkg::SEQ_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (reply.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		ping_q <= ping_d;
		if (load) begin
			ob_q <= load_byte;
			ol_q <= load_last;
		end
	end

	assign idle             = (state_q == dfcr_pkg::SEQ_IDLE);
	assign reply.valid      = ov_q;
	assign reply.reply_byte = ob_q;
	assign reply.reply_last = ol_q;

`ifndef SYNTHESIS
	a_launch_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.launch |-> (state_q == dfcr_pkg::SEQ_IDLE))
		else $error("reply launched while another is in progress");
	a_stuff_after_dle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfcr_pkg::SEQ_STUFF) |-> (ov_q && ob_q == dfcr_pkg::DLE))
		else $error("stuffing byte not preceded by a data DLE");
	a_etx_after_dle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dfcr_pkg::SEQ_EOF_ETX) |-> (ov_q && ob_q == dfcr_pkg::DLE && !ol_q))
		else $error("closing ETX not preceded by DLE");
`endif

endmodule

@@ hw/rtl/dle_framed_command_responder.sv @@
// dle framed command responder
// rx: one received byte per transaction; frames are DLE STX payload DLE ETX,
// with DLE DLE standing for a payload 0x10 and DLE plus any other byte
// aborting the frame. once RECORD_LEN payload bytes are held a lone DLE
// also closes the frame
// reply: one wire byte per transaction, reply_last set on the closing ETX.
// a non-empty frame gives a stuffed reply of 4 + RECORD_LEN to
// 4 + 2 * RECORD_LEN bytes (11 to 18 by default): the ping record when the
// payload opens 4A 55 0F, otherwise the first RECORD_LEN payload bytes
// padded with zeros
// the closing byte's transaction moves the sequencer out of idle; the first
// reply byte is then loaded into a single output register, and the
// sequencer puts out one byte per cycle through it while reply is ready
// throughput: rx accepts one non-closing byte per cycle; rx ready is low from
// the closing transaction until the ETX is loaded into the output register
// a stall on reply holds the output register and the sequencer in place
// reset clears the framing state and any reply in progress; no frame is open
module dle_framed_command_responder #(
	parameter int MAX_PAYLOAD = 64,
	parameter int RECORD_LEN = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	dfcr_rx_if.sink       rx,
	dfcr_reply_if.source  reply
);

	localparam int CNT_MAX = (MAX_PAYLOAD > RECORD_LEN) ? MAX_PAYLOAD : RECORD_LEN;
	localparam int CNT_W = $clog2(CNT_MAX + 1);

	logic                       idle;
	logic                       accept;
	logic [CNT_W-1:0]           count;
	logic [RECORD_LEN-1:0][7:0] store;
	dfcr_pkg::frame_ctl_t       ctl;

	assign rx.ready = idle;
	assign accept   = rx.valid && idle;

	dfcr_deframer #(
		.MAX_PAYLOAD(MAX_PAYLOAD),
		.RECORD_LEN(RECORD_LEN),
		.CNT_W(CNT_W)
	) u_deframer (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.rx_byte(rx.rx_byte),
		.count(count),
		.store(store),
		.ctl(ctl)
	);

	dfcr_reply_seq #(
		.RECORD_LEN(RECORD_LEN),
		.CNT_W(CNT_W)
	) u_reply_seq (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.count(count),
		.store(store),
		.idle(idle),
		.reply(reply)
	);

endmodule
